// ----- src/tqsa_pkg.sv -----
package tqsa_pkg;

    localparam logic [2:0] CMD_ENQ_ONE   = 3'd0;
    localparam logic [2:0] CMD_ENQ_TWO   = 3'd1;
    localparam logic [2:0] CMD_DEQ_ONE   = 3'd2;
    localparam logic [2:0] CMD_DEQ_TWO   = 3'd3;
    localparam logic [2:0] CMD_READ_ONE  = 3'd4;
    localparam logic [2:0] CMD_READ_TWO  = 3'd5;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_OVER  = 2'd1;
    localparam logic [1:0] STAT_UNDER = 2'd2;
    localparam logic [1:0] STAT_EMPTY = 2'd3;

    localparam int unsigned DATA_W = 32;

    // front queue between classifier and executor
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QUEUE_PW    = 1;
    localparam int unsigned QUEUE_CW    = 2;

    typedef enum logic [2:0] {
        OP_ENQ_ONE,
        OP_ENQ_TWO,
        OP_DEQ_ONE,
        OP_DEQ_TWO,
        OP_READ_ONE,
        OP_READ_TWO
    } op_t;

    typedef enum logic [0:0] {
        ST_RUN,
        ST_READ
    } back_state_t;

    typedef struct packed {
        logic [2:0]               command;
        logic signed [DATA_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] data;
        logic [1:0]               status;
        logic                     last;
    } out_item_t;

    typedef struct packed {
        op_t               op;
        logic [DATA_W-1:0] value;
    } job_t;

endpackage

// ----- src/tqsa_ram.sv -----
module tqsa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- src/tqsa_front.sv -----
module tqsa_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  tqsa_pkg::in_item_t item,
    output logic              job_valid,
    output tqsa_pkg::job_t    job,
    input  logic              job_pop
);

    tqsa_pkg::job_t                  entry_reg [tqsa_pkg::QUEUE_DEPTH];
    logic [tqsa_pkg::QUEUE_PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [tqsa_pkg::QUEUE_PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [tqsa_pkg::QUEUE_CW-1:0]   count_reg, count_next;
    tqsa_pkg::job_t                  job_next;
    logic                            cmd_known;
    logic                            push;
    logic                            pop;

    // classify the incoming transaction
    always_comb
    begin
        cmd_known      = 1'b1;
        job_next.value = item.value;
        job_next.op    = tqsa_pkg::OP_ENQ_ONE;
        unique case (item.command)
            tqsa_pkg::CMD_ENQ_ONE:  job_next.op = tqsa_pkg::OP_ENQ_ONE;
            tqsa_pkg::CMD_ENQ_TWO:  job_next.op = tqsa_pkg::OP_ENQ_TWO;
            tqsa_pkg::CMD_DEQ_ONE:  job_next.op = tqsa_pkg::OP_DEQ_ONE;
            tqsa_pkg::CMD_DEQ_TWO:  job_next.op = tqsa_pkg::OP_DEQ_TWO;
            tqsa_pkg::CMD_READ_ONE: job_next.op = tqsa_pkg::OP_READ_ONE;
            tqsa_pkg::CMD_READ_TWO: job_next.op = tqsa_pkg::OP_READ_TWO;
            default:                cmd_known   = 1'b0;
        endcase
    end

    assign busy      = (count_reg == tqsa_pkg::QUEUE_CW'(tqsa_pkg::QUEUE_DEPTH));
    assign push      = start && !busy && cmd_known;
    assign job_valid = (count_reg != '0);
    assign pop       = job_pop && job_valid;
    assign job       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + tqsa_pkg::QUEUE_PW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + tqsa_pkg::QUEUE_PW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + tqsa_pkg::QUEUE_CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - tqsa_pkg::QUEUE_CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= job_next;
        end
    end

endmodule

// ----- src/tqsa_back.sv -----
module tqsa_back #(
    parameter int DEPTH = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               job_valid,
    input  tqsa_pkg::job_t     job,
    output logic               job_pop,
    output logic               strobe,
    output tqsa_pkg::out_item_t result
);

    localparam int AW = $clog2(DEPTH);
    localparam int PW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] TOP = PW'(DEPTH);

    tqsa_pkg::back_state_t state_reg, state_next;
    logic [PW-1:0] h1_reg, h1_next, t1_reg, t1_next;
    logic [PW-1:0] h2_reg, h2_next, t2_reg, t2_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic          which_reg, which_next;
    logic          out_valid_reg, out_valid_next;
    logic [1:0]    out_status_reg, out_status_next;
    logic          out_last_reg, out_last_next;
    logic          out_ram_reg, out_ram_next;

    logic                        we;
    logic [AW-1:0]               waddr;
    logic [AW-1:0]               raddr;
    logic [tqsa_pkg::DATA_W-1:0] rdata;

    logic [PW-1:0] h1_inc, h2_dec, h2_dec2, t2_dec, idx_wide, idx_inc;
    logic          full;

    assign h1_inc   = h1_reg + PW'(1);
    assign h2_dec   = h2_reg - PW'(1);
    assign h2_dec2  = h2_reg - PW'(2);
    assign t2_dec   = t2_reg - PW'(1);
    assign idx_wide = PW'(idx_reg);
    assign idx_inc  = idx_wide + PW'(1);
    assign full     = (t1_reg == t2_reg);

    tqsa_ram #(
        .WIDTH(tqsa_pkg::DATA_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(job.value),
        .raddr(raddr),
        .rdata(rdata)
    );

    always_comb
    begin
        state_next      = state_reg;
        h1_next         = h1_reg;
        t1_next         = t1_reg;
        h2_next         = h2_reg;
        t2_next         = t2_reg;
        idx_next        = idx_reg;
        which_next      = which_reg;
        out_valid_next  = 1'b0;
        out_status_next = tqsa_pkg::STAT_OK;
        out_last_next   = 1'b1;
        out_ram_next    = 1'b0;
        we              = 1'b0;
        waddr           = t1_reg[AW-1:0];
        raddr           = idx_reg;
        job_pop         = 1'b0;
        unique case (state_reg)
            tqsa_pkg::ST_RUN:
            begin
                if (job_valid)
                begin
                    job_pop        = 1'b1;
                    out_valid_next = 1'b1;
                    unique case (job.op)
                        tqsa_pkg::OP_ENQ_ONE:
                        begin
                            if (full)
                            begin
                                out_status_next = tqsa_pkg::STAT_OVER;
                            end
                            else
                            begin
                                we      = 1'b1;
                                waddr   = t1_reg[AW-1:0];
                                t1_next = t1_reg + PW'(1);
                            end
                        end
                        tqsa_pkg::OP_ENQ_TWO:
                        begin
                            if (full)
                            begin
                                out_status_next = tqsa_pkg::STAT_OVER;
                            end
                            else
                            begin
                                we      = 1'b1;
                                waddr   = t2_dec[AW-1:0];
                                t2_next = t2_dec;
                            end
                        end
                        tqsa_pkg::OP_DEQ_ONE:
                        begin
                            if (h1_reg == t1_reg)
                            begin
                                out_status_next = tqsa_pkg::STAT_UNDER;
                            end
                            else
                            begin
                                raddr        = h1_reg[AW-1:0];
                                out_ram_next = 1'b1;
                                if (h1_inc == t1_reg)
                                begin
                                    h1_next = '0;
                                    t1_next = '0;
                                end
                                else
                                begin
                                    h1_next = h1_inc;
                                end
                            end
                        end
                        tqsa_pkg::OP_DEQ_TWO:
                        begin
                            if (h2_reg == t2_reg)
                            begin
                                out_status_next = tqsa_pkg::STAT_UNDER;
                            end
                            else
                            begin
                                raddr        = h2_dec[AW-1:0];
                                out_ram_next = 1'b1;
                                if (h2_dec == t2_reg)
                                begin
                                    h2_next = TOP;
                                    t2_next = TOP;
                                end
                                else
                                begin
                                    h2_next = h2_dec;
                                end
                            end
                        end
                        tqsa_pkg::OP_READ_ONE:
                        begin
                            if (h1_reg == t1_reg)
                            begin
                                out_status_next = tqsa_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                raddr         = h1_reg[AW-1:0];
                                out_ram_next  = 1'b1;
                                out_last_next = (h1_inc == t1_reg);
                                if (h1_inc != t1_reg)
                                begin
                                    state_next = tqsa_pkg::ST_READ;
                                    idx_next   = h1_inc[AW-1:0];
                                    which_next = 1'b0;
                                end
                            end
                        end
                        tqsa_pkg::OP_READ_TWO:
                        begin
                            if (h2_reg == t2_reg)
                            begin
                                out_status_next = tqsa_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                raddr         = h2_dec[AW-1:0];
                                out_ram_next  = 1'b1;
                                out_last_next = (h2_dec == t2_reg);
                                if (h2_dec != t2_reg)
                                begin
                                    state_next = tqsa_pkg::ST_READ;
                                    idx_next   = h2_dec2[AW-1:0];
                                    which_next = 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                            out_valid_next = 1'b0;
                        end
                    endcase
                end
            end
            tqsa_pkg::ST_READ:
            begin
                raddr          = idx_reg;
                out_valid_next = 1'b1;
                out_ram_next   = 1'b1;
                out_last_next  = which_reg ? (idx_wide == t2_reg) : (idx_inc == t1_reg);
                if (out_last_next)
                begin
                    state_next = tqsa_pkg::ST_RUN;
                end
                else if (which_reg)
                begin
                    idx_next = idx_reg - AW'(1);
                end
                else
                begin
                    idx_next = idx_reg + AW'(1);
                end
            end
            default:
            begin
                state_next = tqsa_pkg::ST_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tqsa_pkg::ST_RUN;
            h1_reg        <= '0;
            t1_reg        <= '0;
            h2_reg        <= TOP;
            t2_reg        <= TOP;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            h1_reg        <= h1_next;
            t1_reg        <= t1_next;
            h2_reg        <= h2_next;
            t2_reg        <= t2_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        which_reg      <= which_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
        out_ram_reg    <= out_ram_next;
    end

    assign strobe        = out_valid_reg;
    assign result.data   = out_ram_reg ? rdata : '0;
    assign result.status = out_status_reg;
    assign result.last   = out_last_reg;

    a_tails_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        t1_reg <= t2_reg)
        else $error("queue tails crossed");

    a_heads_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (h1_reg <= t1_reg) && (t2_reg <= h2_reg) && (h2_reg <= TOP))
        else $error("queue head outside its queue");

    a_read_emits: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == tqsa_pkg::ST_READ |=> out_valid_reg && out_ram_reg)
        else $error("readout step gave no result");

    a_read_holds_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == tqsa_pkg::ST_READ |=> $stable(t1_reg) && $stable(t2_reg)
            && $stable(h1_reg) && $stable(h2_reg))
        else $error("pointers moved during readout");

endmodule

// ----- src/two_queues_shared_array.sv -----
// channel   handshake                  payload
// item      start high, busy low       in_item_t  (command, value)
// result    strobe high, one cycle     out_item_t (data, status, last)
//
// enqueue and dequeue: one transaction per cycle outside readout, result registered
// readout: elements read one after another from the single ram read port
// reset: pointers return to empty, front queue empty, no clearing pass
// busy rises when the two-entry front queue is full, mostly during a long readout
// results cannot be stalled by the receiver
module two_queues_shared_array #(
    parameter int DEPTH = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  tqsa_pkg::in_item_t  item,
    output logic               strobe,
    output tqsa_pkg::out_item_t result
);

    logic           job_valid;
    logic           job_pop;
    tqsa_pkg::job_t job;

    tqsa_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .item     (item),
        .job_valid(job_valid),
        .job      (job),
        .job_pop  (job_pop)
    );

    tqsa_back #(
        .DEPTH(DEPTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .job_valid(job_valid),
        .job      (job),
        .job_pop  (job_pop),
        .strobe   (strobe),
        .result   (result)
    );

endmodule
